// ===== src/tosm_pkg.sv =====
// shared constants, codes and transaction types for the timestamp ordered stream merge
package tosm_pkg;

  localparam int LANES      = 8;
  localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LANE_W     = 3;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int TS_W       = 64;
  localparam int TAG_W      = 32;
  localparam int QCOUNT_W   = 2;

  localparam logic [LANE_IDX_W-1:0] LAST_LANE = LANE_IDX_W'(LANES - 1);

  localparam logic [KIND_W-1:0] KIND_OFFER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_EMIT = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_END  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

  localparam logic signed [TS_W-1:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [TS_W-1:0] TS_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [QCOUNT_W-1:0] QUEUE_DEPTH = 2'd2;

  // decoded operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_OFFER,
    OP_END,
    OP_ATTACH
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [LANE_IDX_W-1:0]  lane;
    logic signed [TS_W-1:0] ts;
    logic                   timed;
    logic                   absolute;
    logic [TAG_W-1:0]       tag;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [LANE_W-1:0]      lane;
    logic signed [TS_W-1:0] ts;
    logic [TAG_W-1:0]       tag;
  } res_t;

endpackage

// ===== src/tosm_front.sv =====
// front end: accepts input transactions, decodes them and queues commands for the back end
module tosm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [tosm_pkg::KIND_W-1:0]    kind,
  input  logic [tosm_pkg::LANE_W-1:0]    lane,
  input  logic signed [tosm_pkg::TS_W-1:0] timestamp,
  input  logic                           has_time,
  input  logic                           clock_absolute,
  input  logic [tosm_pkg::TAG_W-1:0]     item_tag,
  output logic                           cmd_valid,
  output tosm_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);
  import tosm_pkg::*;

  cmd_t                cmd_in;
  cmd_t                q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                do_push;
  logic                lane_ok;

  // decode kind and lane range into an operation
  always_comb begin
    lane_ok         = int'(lane) < LANES;
    cmd_in.lane     = LANE_IDX_W'(lane);
    cmd_in.ts       = timestamp;
    cmd_in.timed    = has_time;
    cmd_in.absolute = clock_absolute;
    cmd_in.tag      = item_tag;
    cmd_in.op       = OP_NONE;
    if (lane_ok) begin
      unique case (kind)
        KIND_OFFER:  cmd_in.op = OP_OFFER;
        KIND_END:    cmd_in.op = OP_END;
        KIND_ATTACH: cmd_in.op = OP_ATTACH;
        default:     cmd_in.op = OP_NONE;
      endcase
    end
  end

  assign full      = (count == QUEUE_DEPTH);
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + QCOUNT_W'(do_push) - QCOUNT_W'(cmd_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cmd_in;
  end

endmodule

// ===== src/tosm_back.sv =====
// back end: lane state, head storage, youngest head scan and error tracking
module tosm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_data,
  input  logic                             cmd_valid,
  input  tosm_pkg::cmd_t                   cmd,
  output logic                             cmd_pop,
  input  logic [tosm_pkg::QCOUNT_W-1:0]    res_count,
  output logic                             res_push,
  output tosm_pkg::res_t                   res_data
);
  import tosm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINAL
  } state_t;

  state_t                 state;
  logic [LANES-1:0]       live;
  logic [LANES-1:0]       holds;
  logic signed [TS_W-1:0] head_time [LANES];
  logic [TAG_W-1:0]       head_tag [LANES];
  logic [LANES-1:0]       head_timed;
  logic [LANES-1:0]       head_abs;
  logic signed [TS_W-1:0] last_time;
  logic                   error_seen;
  logic                   allow_rel;

  logic [LANE_IDX_W-1:0]  idx;
  logic [LANE_IDX_W-1:0]  pick;
  logic signed [TS_W-1:0] best;
  logic [TAG_W-1:0]       best_tag;
  logic                   rel_err;

  logic                   res_room;
  logic [LANES-1:0]       lane_bit;
  logic [LANES-1:0]       live_after_end;
  logic signed [TS_W-1:0] scan_t;
  logic                   scan_rel_bad;
  logic                   scan_take;
  logic                   head_write;

  // room for one result, counting a push still on its way
  assign res_room = (res_count == '0) || ((res_count == QCOUNT_W'(1)) && !res_push);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid && res_room;

  assign lane_bit       = {{(LANES-1){1'b0}}, 1'b1} << cmd.lane;
  assign live_after_end = live & ~lane_bit;

  // one lane per cycle: effective time and checks of the scanned head
  assign scan_t       = head_timed[idx] ? head_time[idx] : last_time;
  assign scan_rel_bad = live[idx] && head_timed[idx] && !allow_rel && !head_abs[idx];
  assign scan_take    = live[idx] && (scan_t <= best);

  assign head_write = cmd_pop && !error_seen && (cmd.op == OP_OFFER) && live[cmd.lane];

  // head storage
  always_ff @(posedge clk) begin
    if (head_write) begin
      head_time[cmd.lane]  <= cmd.ts;
      head_tag[cmd.lane]   <= cmd.tag;
      head_timed[cmd.lane] <= cmd.timed;
      head_abs[cmd.lane]   <= cmd.absolute;
    end
  end

  // control state machine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      holds      <= '0;
      last_time  <= TS_MIN;
      error_seen <= 1'b0;
      allow_rel  <= 1'b0;
      res_push   <= 1'b0;
    end else begin
      res_push <= 1'b0;
      if (cfg_we) allow_rel <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (error_seen) begin
              res_push <= 1'b1;
              res_data <= '{status: STATUS_ERR, lane: '0, ts: '0, tag: '0};
            end else begin
              unique case (cmd.op)
                OP_ATTACH: begin
                  live[cmd.lane]  <= 1'b1;
                  holds[cmd.lane] <= 1'b0;
                end
                OP_OFFER: begin
                  if (live[cmd.lane]) begin
                    holds[cmd.lane] <= 1'b1;
                    state           <= S_CHECK;
                  end
                end
                OP_END: begin
                  if (live[cmd.lane]) begin
                    live            <= live_after_end;
                    holds[cmd.lane] <= 1'b0;
                    if (live_after_end == '0) begin
                      res_push <= 1'b1;
                      res_data <= '{status: STATUS_END, lane: '0, ts: '0, tag: '0};
                    end else begin
                      state <= S_CHECK;
                    end
                  end
                end
                OP_NONE: begin
                end
              endcase
            end
          end
        end
        // every live lane must hold a head before a scan
        S_CHECK: begin
          if ((live == '0) || ((live & ~holds) != '0)) begin
            state <= S_IDLE;
          end else begin
            idx     <= '0;
            pick    <= '0;
            best    <= TS_MAX;
            rel_err <= 1'b0;
            state   <= S_SCAN;
          end
        end
        // later lanes win ties through the inclusive compare
        S_SCAN: begin
          if (scan_rel_bad) rel_err <= 1'b1;
          if (scan_take) begin
            best     <= scan_t;
            pick     <= idx;
            best_tag <= head_tag[idx];
          end
          if (idx == LAST_LANE) begin
            state <= S_FINAL;
          end else begin
            idx <= idx + LANE_IDX_W'(1);
          end
        end
        // emit the winner or raise the sticky error
        S_FINAL: begin
          res_push <= 1'b1;
          if (rel_err || !(last_time <= best)) begin
            error_seen <= 1'b1;
            res_data   <= '{status: STATUS_ERR, lane: '0, ts: '0, tag: '0};
          end else begin
            holds[pick] <= 1'b0;
            last_time   <= best;
            res_data    <= '{status: STATUS_EMIT, lane: LANE_W'(pick), ts: best,
                             tag: best_tag};
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/tosm_result_queue.sv =====
// two-entry result queue between the back end and the result ports
module tosm_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  tosm_pkg::res_t                din,
  output logic [tosm_pkg::QCOUNT_W-1:0] count,
  output logic                          empty,
  output tosm_pkg::res_t                dout,
  input  logic                          pop
);
  import tosm_pkg::*;

  res_t q [2];
  logic wr_ptr;
  logic rd_ptr;
  logic do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = q[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + QCOUNT_W'(push) - QCOUNT_W'(do_pop);
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= din;
  end

endmodule

// ===== src/timestamp_ordered_stream_merge.sv =====
// top level of the timestamp ordered stream merge
// an item whose scan runs passes the command queue, the check, the lane scan and the
//   final state before its result is queued; end of the last lane and error replies
//   are queued straight from the idle state; when the scan runs, the rate is set by the
//   one-lane-per-cycle youngest head scan, and no new command is taken until it is done
// reset: synchronous; clears lane flags, error, last time, config and both queues;
//   head storage is not cleared and needs no clearing pass
module timestamp_ordered_stream_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [tosm_pkg::KIND_W-1:0]        kind,
  input  logic [tosm_pkg::LANE_W-1:0]        lane,
  input  logic signed [tosm_pkg::TS_W-1:0]   timestamp,
  input  logic                               has_time,
  input  logic                               clock_absolute,
  input  logic [tosm_pkg::TAG_W-1:0]         item_tag,
  output logic                               empty,
  input  logic                               pop,
  output logic [tosm_pkg::STATUS_W-1:0]      status,
  output logic [tosm_pkg::LANE_W-1:0]        out_lane,
  output logic signed [tosm_pkg::TS_W-1:0]   out_timestamp,
  output logic [tosm_pkg::TAG_W-1:0]         out_tag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               allow_relative_clock
);
  import tosm_pkg::*;

  cmd_t                cmd;
  logic                cmd_valid;
  logic                cmd_pop;
  logic                res_push;
  res_t                res_data;
  res_t                res_head;
  logic [QCOUNT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  // decode and command queue
  tosm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .lane           (lane),
    .timestamp      (timestamp),
    .has_time       (has_time),
    .clock_absolute (clock_absolute),
    .item_tag       (item_tag),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // lane state and scan
  tosm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (allow_relative_clock),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result queue
  tosm_result_queue u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_data),
    .count (res_count),
    .empty (empty),
    .dout  (res_head),
    .pop   (pop)
  );

  assign status        = res_head.status;
  assign out_lane      = res_head.lane;
  assign out_timestamp = res_head.ts;
  assign out_tag       = res_head.tag;

  // a result is only pushed when the queue has room for it
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_count != QUEUE_DEPTH))
    else $error("result pushed into a full queue");

  // the back end only takes a command that is there
  a_cmd_pop: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // the result queue is empty and the command queue not full right after reset
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

// ===== tb/merge_order_checker.sv =====
// checker for the timestamp ordered stream merge: predicts results and compares them
`timescale 1ns / 100ps

module merge_order_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic [tosm_pkg::KIND_W-1:0]        kind,
  input  logic [tosm_pkg::LANE_W-1:0]        lane,
  input  logic signed [tosm_pkg::TS_W-1:0]   timestamp,
  input  logic                               has_time,
  input  logic                               clock_absolute,
  input  logic [tosm_pkg::TAG_W-1:0]         item_tag,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [tosm_pkg::STATUS_W-1:0]      status,
  input  logic [tosm_pkg::LANE_W-1:0]        out_lane,
  input  logic signed [tosm_pkg::TS_W-1:0]   out_timestamp,
  input  logic [tosm_pkg::TAG_W-1:0]         out_tag,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic                               allow_relative_clock,
  output int                                 fail_count,
  output int                                 outstanding,
  output logic signed [tosm_pkg::TS_W-1:0]   emitted_floor
);

  import tosm_pkg::*;

  // shadow of the merge state
  logic [LANES-1:0]       lane_up;
  logic [LANES-1:0]       lane_held;
  logic signed [TS_W-1:0] head_ts [LANES];
  logic [LANES-1:0]       head_timed;
  logic [LANES-1:0]       head_abs;
  logic [TAG_W-1:0]       head_tag [LANES];
  logic signed [TS_W-1:0] last_time;
  logic                   error_latched;
  logic                   relative_ok;

  // merge results still owed by the block, oldest first
  res_t due_results [$];
  res_t want;

  assign emitted_floor = last_time;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic owe_result(input logic [STATUS_W-1:0] st, input logic [LANE_W-1:0] ln,
                            input logic signed [TS_W-1:0] ts, input logic [TAG_W-1:0] tg);
    res_t r;
    r.status = st;
    r.lane   = ln;
    r.ts     = ts;
    r.tag    = tg;
    due_results.push_back(r);
  endtask

  // emit the youngest head, or owe an error, once every live lane holds one; ties go to the highest lane
  task automatic pick_youngest();
    logic signed [TS_W-1:0] best;
    logic signed [TS_W-1:0] t;
    int                     pick;
    logic                   bad;
    if (lane_up == '0) return;
    if ((lane_up & ~lane_held) != '0) return;
    best = TS_MAX;
    pick = 0;
    bad  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_up[i] && !bad) begin
        if (head_timed[i] && !relative_ok && !head_abs[i]) begin
          bad = 1'b1;
        end else begin
          t = head_timed[i] ? head_ts[i] : last_time;
          if (t <= best) begin
            best = t;
            pick = i;
          end
        end
      end
    end
    // relative clock refused, or time going backwards
    if (bad || last_time > best) begin
      error_latched = 1'b1;
      owe_result(STATUS_ERR, '0, '0, '0);
      return;
    end
    lane_held[pick] = 1'b0;
    last_time       = best;
    owe_result(STATUS_EMIT, LANE_W'(pick), best, head_tag[pick]);
  endtask

  // one accepted input transaction
  task automatic merge_step(input logic [KIND_W-1:0] k, input logic [LANE_W-1:0] ln,
                            input logic signed [TS_W-1:0] ts, input logic timed,
                            input logic absolute_clk, input logic [TAG_W-1:0] tg);
    if (error_latched) begin
      owe_result(STATUS_ERR, '0, '0, '0);
      return;
    end
    if (int'(ln) >= LANES) return;
    case (k)
      KIND_OFFER: begin
        if (lane_up[ln]) begin
          head_ts[ln]    = ts;
          head_timed[ln] = timed;
          head_abs[ln]   = absolute_clk;
          head_tag[ln]   = tg;
          lane_held[ln]  = 1'b1;
          pick_youngest();
        end
      end
      KIND_END: begin
        if (lane_up[ln]) begin
          lane_up[ln]   = 1'b0;
          lane_held[ln] = 1'b0;
          if (lane_up == '0) owe_result(STATUS_END, '0, '0, '0);
          else pick_youngest();
        end
      end
      KIND_ATTACH: begin
        lane_up[ln]   = 1'b1;
        lane_held[ln] = 1'b0;
      end
      default: ;
    endcase
  endtask

  // watch the three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      lane_up       = '0;
      lane_held     = '0;
      head_timed    = '0;
      head_abs      = '0;
      last_time     = TS_MIN;
      error_latched = 1'b0;
      relative_ok   = 1'b0;
      due_results.delete();
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d lane %0d ts %0d tag %h",
                                  status, out_lane, out_timestamp, out_tag));
        end else begin
          want = due_results.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
          if (out_lane !== want.lane)
            flag_mismatch($sformatf("lane %0d, wanted %0d", out_lane, want.lane));
          if (out_timestamp !== want.ts)
            flag_mismatch($sformatf("timestamp %0d, wanted %0d", out_timestamp, want.ts));
          if (out_tag !== want.tag)
            flag_mismatch($sformatf("tag %h, wanted %h", out_tag, want.tag));
        end
      end
      if (cfg_valid && cfg_ready) relative_ok = allow_relative_clock;
      if (push && !full)
        merge_step(kind, lane, timestamp, has_time, clock_absolute, item_tag);
    end
    outstanding = due_results.size();
  end

endmodule

// ===== tb/timestamp_ordered_stream_merge_test.sv =====
// testbench top for the timestamp ordered stream merge: stimulus, idling and verdict
`timescale 1ns / 100ps

module timestamp_ordered_stream_merge_test;

  import tosm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic [KIND_W-1:0]      kind = KIND_OFFER;
  logic [LANE_W-1:0]      lane = '0;
  logic signed [TS_W-1:0] timestamp = '0;
  logic                   has_time = 1'b0;
  logic                   clock_absolute = 1'b0;
  logic [TAG_W-1:0]       item_tag = '0;
  logic                   pop = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   allow_relative_clock = 1'b0;

  logic                   full;
  logic                   empty;
  logic                   cfg_ready;
  logic [STATUS_W-1:0]    status;
  logic [LANE_W-1:0]      out_lane;
  logic signed [TS_W-1:0] out_timestamp;
  logic [TAG_W-1:0]       out_tag;

  int                     fail_count;
  int                     outstanding;
  logic signed [TS_W-1:0] emitted_floor;

  logic                   push_taken = 1'b0;
  logic                   cfg_taken = 1'b0;
  int                     send_idle_pct = 0;
  int                     take_stall_pct = 0;
  int                     hold_left = 0;
  logic [LANES-1:0]       lanes_up = '0;
  logic                   cfg_now = 1'b0;

  int idle_tab [4]  = '{0, 81, 0, 9};
  int stall_tab [4] = '{0, 0, 81, 9};

  always #6 clk = ~clk;

  timestamp_ordered_stream_merge u_top (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .kind                 (kind),
    .lane                 (lane),
    .timestamp            (timestamp),
    .has_time             (has_time),
    .clock_absolute       (clock_absolute),
    .item_tag             (item_tag),
    .empty                (empty),
    .pop                  (pop),
    .status               (status),
    .out_lane             (out_lane),
    .out_timestamp        (out_timestamp),
    .out_tag              (out_tag),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .allow_relative_clock (allow_relative_clock)
  );

  merge_order_checker u_check (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .kind                 (kind),
    .lane                 (lane),
    .timestamp            (timestamp),
    .has_time             (has_time),
    .clock_absolute       (clock_absolute),
    .item_tag             (item_tag),
    .empty                (empty),
    .pop                  (pop),
    .status               (status),
    .out_lane             (out_lane),
    .out_timestamp        (out_timestamp),
    .out_tag              (out_tag),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .allow_relative_clock (allow_relative_clock),
    .fail_count           (fail_count),
    .outstanding          (outstanding),
    .emitted_floor        (emitted_floor)
  );

  // handshake completions as seen at the rising edge
  always @(posedge clk) begin
    push_taken <= push && !full;
    cfg_taken  <= cfg_valid && cfg_ready;
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= take_stall_pct);
      end
    end
  end

  // one input transaction, with an optional random gap in front
  task automatic send(input logic [KIND_W-1:0] k, input logic [LANE_W-1:0] ln,
                      input logic signed [TS_W-1:0] ts, input logic timed,
                      input logic absolute_clk, input logic [TAG_W-1:0] tg);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push           <= 1'b1;
    kind           <= k;
    lane           <= ln;
    timestamp      <= ts;
    has_time       <= timed;
    clock_absolute <= absolute_clk;
    item_tag       <= tg;
    do @(negedge clk); while (!push_taken);
    if (k == KIND_ATTACH) lanes_up[ln] = 1'b1;
    else if (k == KIND_END) lanes_up[ln] = 1'b0;
  endtask

  // a time no earlier than the last emitted one, saturating at the top
  function automatic logic signed [TS_W-1:0] later_time();
    logic [TS_W-1:0] room;
    logic [TS_W-1:0] step;
    room = TS_MAX - emitted_floor;
    case ($urandom_range(19))
      0:       step = {$urandom, $urandom} % ((room >> 2) + 1);
      1, 2, 3: step = TS_W'($urandom);
      default: step = TS_W'($urandom_range(15));
    endcase
    if (step > room) return TS_MAX;
    return emitted_floor + step;
  endfunction

  // random lane whose live flag matches
  function automatic logic [LANE_W-1:0] lane_with(input logic up);
    logic [LANE_W-1:0] l;
    do l = LANE_W'($urandom_range(LANES - 1)); while (lanes_up[l] != up);
    return l;
  endfunction

  // register write once the block has gone quiet
  task automatic set_relative(input logic v);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid            <= 1'b1;
    allow_relative_clock <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cfg_now = v;
  endtask

  // mostly well-formed lane traffic, some ignored noise
  task automatic random_phase(input int n);
    int               done;
    int               pick;
    logic [LANE_W-1:0] ln;
    logic             timed;
    logic             absolute_clk;
    done = 0;
    while (done < n) begin
      pick         = $urandom_range(99);
      ln           = LANE_W'($urandom_range(LANES - 1));
      timed        = ($urandom_range(4) != 0);
      absolute_clk = (cfg_now || !timed) ? 1'($urandom_range(1)) : 1'b1;
      if (lanes_up == '0 || pick < 10) begin
        send(KIND_ATTACH, ln, {$urandom, $urandom}, 1'($urandom_range(1)),
             1'($urandom_range(1)), $urandom);
        done++;
      end else if (pick < 25) begin
        send(KIND_END, lane_with(1'b1), {$urandom, $urandom}, 1'($urandom_range(1)),
             1'($urandom_range(1)), $urandom);
        done++;
      end else if (pick < 90) begin
        send(KIND_OFFER, lane_with(1'b1), timed ? later_time() : {$urandom, $urandom},
             timed, absolute_clk, $urandom);
        done++;
      end else if (lanes_up != '1 && $urandom_range(1)) begin
        send($urandom_range(1) ? KIND_OFFER : KIND_END, lane_with(1'b0),
             {$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      end else begin
        send(KIND_UNUSED, ln, {$urandom, $urandom}, 1'($urandom_range(1)),
             1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ignored transactions on a fresh block
    send(KIND_OFFER, 3'd3, 64'sd5, 1'b1, 1'b1, 32'h0000_0001);
    send(KIND_END, 3'd5, '0, 1'b0, 1'b0, '0);
    send(KIND_UNUSED, 3'd0, '0, 1'b0, 1'b0, '0);
    // ties at the lowest time go to the highest lane, untimed head included
    send(KIND_ATTACH, 3'd0, '0, 1'b0, 1'b0, '0);
    send(KIND_ATTACH, 3'd7, '0, 1'b0, 1'b0, '0);
    send(KIND_OFFER, 3'd0, TS_MIN, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send(KIND_OFFER, 3'd7, 64'sh1234_5678_9ABC_DEF0, 1'b0, 1'b0, 32'h0000_0000);
    send(KIND_OFFER, 3'd7, TS_MIN, 1'b1, 1'b1, 32'hA5A5_A5A5);
    // head overwrite, then the top time left waiting and dropped by a re-attach
    send(KIND_OFFER, 3'd0, -64'sd1, 1'b1, 1'b1, 32'h5A5A_5A5A);
    send(KIND_OFFER, 3'd7, TS_MAX, 1'b1, 1'b1, 32'h0F0F_0F0F);
    send(KIND_ATTACH, 3'd7, '0, 1'b0, 1'b0, '0);
    send(KIND_OFFER, 3'd0, 64'sd0, 1'b1, 1'b1, 32'h1111_1111);
    send(KIND_ATTACH, 3'd3, '0, 1'b0, 1'b0, '0);
    // end of a lane with others still live
    send(KIND_END, 3'd7, '0, 1'b0, 1'b0, '0);
    send(KIND_OFFER, 3'd3, 64'sh5555_5555_5555_5555, 1'b1, 1'b1, 32'h2222_2222);
    send(KIND_OFFER, 3'd0, 64'sd0, 1'b0, 1'b1, 32'h3333_3333);
    send(KIND_END, 3'd3, '0, 1'b0, 1'b0, '0);
    send(KIND_OFFER, 3'd0, 64'sh2AAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 32'h4444_4444);
    // last live lane ends
    send(KIND_END, 3'd0, '0, 1'b0, 1'b0, '0);
    send(KIND_OFFER, 3'd0, 64'sd7, 1'b1, 1'b1, 32'h5555_5555);

    // random phases across register settings and idling patterns
    for (int p = 0; p < 4; p++) begin
      set_relative(p % 2 == 0);
      send_idle_pct  = idle_tab[p];
      take_stall_pct = stall_tab[p];
      // attach everything so no stale head survives the setting change
      for (int l = 0; l < LANES; l++)
        send(KIND_ATTACH, LANE_W'(l), '0, 1'b0, 1'b0, '0);
      for (int l = 0; l < LANES; l++) begin
        if (p == 0 ? (l != 2) : (l != 0 && $urandom_range(1)))
          send(KIND_END, LANE_W'(l), '0, 1'b0, 1'b0, '0);
      end
      // result side held off while a single lane keeps emitting
      if (p == 0) begin
        hold_left = 300;
        repeat (30) send(KIND_OFFER, 3'd2, later_time(), 1'b1, 1'b1, $urandom);
      end
      random_phase(70);
    end

    // one lane left, then a relative clock or a backwards time, then the sticky error
    send(KIND_ATTACH, 3'd0, '0, 1'b0, 1'b0, '0);
    for (int l = 1; l < LANES; l++) begin
      if (lanes_up[l]) send(KIND_END, LANE_W'(l), '0, 1'b0, 1'b0, '0);
    end
    if (!cfg_now && $urandom_range(1)) begin
      send(KIND_OFFER, 3'd0, later_time(), 1'b1, 1'b0, $urandom);
    end else begin
      send(KIND_OFFER, 3'd0, later_time(), 1'b1, 1'b1, $urandom);
      send(KIND_OFFER, 3'd0, emitted_floor - 64'sd1, 1'b1, 1'b1, $urandom);
    end
    repeat (8)
      send(KIND_W'($urandom_range(3)), LANE_W'($urandom_range(LANES - 1)),
           {$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);

    // drain, then allow time for anything stray
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tosm_pkg.sv
src/tosm_front.sv
src/tosm_back.sv
src/tosm_result_queue.sv
src/timestamp_ordered_stream_merge.sv
tb/merge_order_checker.sv
tb/timestamp_ordered_stream_merge_test.sv
